// ===== src/srp_pkg.sv =====
// srp_pkg: shared types and constants of the smoothed ramp profile block
// used by every module under src, no dependencies of its own
package srp_pkg;

	localparam int TIME_W    = 32;
	localparam int DUR_W     = 31;
	localparam int SMOOTH_W  = 16;
	localparam int SCOMP_W   = 17;
	localparam int VAL_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int SR_W      = SMOOTH_W + DUR_W;
	localparam int RS_W      = SCOMP_W + DUR_W;
	localparam int DIFF_W    = TIME_W + 1;

	localparam int DIV_QB = 31;
	localparam int DIV_DB = 31;
	localparam int DIV_NB = DIV_QB + DIV_DB;

	localparam int F_W    = 32;
	localparam int PROD_W = VAL_W + F_W;
	localparam int RND_W  = PROD_W - 30;
	localparam int SUM_W  = RND_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_START_TIME    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DURATION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHNESS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_HEIGHT   = 3'd4;

	localparam logic [SMOOTH_W-1:0] S_ONE    = 16'h8000;
	localparam logic [SCOMP_W-1:0]  S_FULL   = 17'h10000;
	localparam logic [DIV_QB-1:0]   U_ONE    = 31'h4000_0000;
	localparam logic [DIV_QB-1:0]   U_HALF   = 31'h2000_0000;
	localparam logic [F_W-1:0]      F_ONE    = 32'h4000_0000;
	localparam logic [F_W-1:0]      F_HALF   = 32'h2000_0000;
	localparam logic [PROD_W-1:0]   RND_HALF = 64'h0000_0000_2000_0000;
	localparam logic [VAL_W-1:0]    VAL_MAX  = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0]    VAL_MIN  = 32'h8000_0000;

	typedef enum logic [2:0] {
		REG_BEFORE = 3'd0,
		REG_LOWER  = 3'd1,
		REG_LINEAR = 3'd2,
		REG_UPPER  = 3'd3,
		REG_AFTER  = 3'd4
	} region_t;

	typedef struct packed {
		logic [TIME_W-1:0]  start_time;
		logic [DUR_W-1:0]   r_eff;
		logic [SCOMP_W-1:0] s_comp;
		logic [SR_W-1:0]    sr;
		logic [RS_W-1:0]    rs;
		logic [DIV_DB-1:0]  dd;
		logic [VAL_W-1:0]   base_offset;
		logic [VAL_W-1:0]   ramp_height;
	} cfg_t;

	typedef struct packed {
		region_t region;
		logic    neg;
	} side_t;

endpackage

// ===== src/srp_cfg_regs.sv =====
// srp_cfg_regs: configuration registers and the products derived from them
// depends on srp_pkg
module srp_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [srp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srp_pkg::CFG_DAT_W-1:0]  cfg_data,
	output srp_pkg::cfg_t                  regs
);

	logic [srp_pkg::TIME_W-1:0]   start_time_q;
	logic [srp_pkg::DUR_W-1:0]    ramp_duration_q;
	logic [srp_pkg::SMOOTH_W-1:0] smoothness_q;
	logic [srp_pkg::VAL_W-1:0]    base_offset_q;
	logic [srp_pkg::VAL_W-1:0]    ramp_height_q;

	logic [srp_pkg::DUR_W-1:0]    r_eff_c;
	logic [srp_pkg::SMOOTH_W-1:0] s_eff_c;
	logic [srp_pkg::SCOMP_W-1:0]  s_comp_c;
	logic [srp_pkg::SR_W-1:0]     sr_c;
	logic [srp_pkg::RS_W-1:0]     rs_c;
	logic [srp_pkg::DIV_DB-1:0]   dd_c;

	logic [srp_pkg::DUR_W-1:0]    r_eff_q;
	logic [srp_pkg::SCOMP_W-1:0]  s_comp_q;
	logic [srp_pkg::SR_W-1:0]     sr_q;
	logic [srp_pkg::RS_W-1:0]     rs_q;
	logic [srp_pkg::DIV_DB-1:0]   dd_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q    <= '0;
			ramp_duration_q <= 31'd1;
			smoothness_q    <= '0;
			base_offset_q   <= '0;
			ramp_height_q   <= 32'd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				srp_pkg::CFG_START_TIME:    start_time_q    <= cfg_data[srp_pkg::TIME_W-1:0];
				srp_pkg::CFG_RAMP_DURATION: ramp_duration_q <= cfg_data[srp_pkg::DUR_W-1:0];
				srp_pkg::CFG_SMOOTHNESS:    smoothness_q    <= cfg_data[srp_pkg::SMOOTH_W-1:0];
				srp_pkg::CFG_BASE_OFFSET:   base_offset_q   <= cfg_data[srp_pkg::VAL_W-1:0];
				srp_pkg::CFG_RAMP_HEIGHT:   ramp_height_q   <= cfg_data[srp_pkg::VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// zero duration acts as one, smoothness clips at one
	assign r_eff_c  = (ramp_duration_q == '0) ? 31'd1 : ramp_duration_q;
	assign s_eff_c  = (smoothness_q > srp_pkg::S_ONE) ? srp_pkg::S_ONE : smoothness_q;
	assign s_comp_c = srp_pkg::S_FULL - {1'b0, s_eff_c};
	assign sr_c     = s_eff_c * r_eff_c;
	assign rs_c     = s_comp_c * r_eff_c;
	assign dd_c     = s_eff_c * s_comp_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_eff_q  <= 31'd1;
			s_comp_q <= srp_pkg::S_FULL;
			sr_q     <= '0;
			rs_q     <= 48'd65536;
			dd_q     <= '0;
		end else begin
			r_eff_q  <= r_eff_c;
			s_comp_q <= s_comp_c;
			sr_q     <= sr_c;
			rs_q     <= rs_c;
			dd_q     <= dd_c;
		end
	end

	always_comb begin
		regs.start_time  = start_time_q;
		regs.r_eff       = r_eff_q;
		regs.s_comp      = s_comp_q;
		regs.sr          = sr_q;
		regs.rs          = rs_q;
		regs.dd          = dd_q;
		regs.base_offset = base_offset_q;
		regs.ramp_height = ramp_height_q;
	end

endmodule

// ===== src/srp_region.sv =====
// srp_region: time difference and region decision, two pipeline stages
// depends on srp_pkg
module srp_region (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [srp_pkg::TIME_W-1:0]  time_tick,
	input  srp_pkg::cfg_t               regs,
	output logic                        valid_s2,
	output srp_pkg::region_t            region_s2,
	output logic [srp_pkg::DUR_W-1:0]   dlow_s2
);

	logic                        valid_s1;
	logic [srp_pkg::DIFF_W-1:0]  d_s1;
	logic [srp_pkg::SR_W-1:0]    d16_c;
	logic                        d_pos_c;
	logic                        gt_r_c;
	logic                        le_lo_c;
	logic                        le_hi_c;
	srp_pkg::region_t            region_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_comb begin
		d16_c   = {d_s1[srp_pkg::DUR_W-1:0], 16'b0};
		d_pos_c = !d_s1[srp_pkg::DIFF_W-1] && (d_s1 != '0);
		gt_r_c  = d_s1 > {2'b00, regs.r_eff};
		le_lo_c = d16_c <= regs.sr;
		le_hi_c = {1'b0, d16_c} <= regs.rs;
		if (!d_pos_c)
			region_c = srp_pkg::REG_BEFORE;
		else if (gt_r_c)
			region_c = srp_pkg::REG_AFTER;
		else if (le_lo_c)
			region_c = srp_pkg::REG_LOWER;
		else if (le_hi_c)
			region_c = srp_pkg::REG_LINEAR;
		else
			region_c = srp_pkg::REG_UPPER;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1      <= {time_tick[srp_pkg::TIME_W-1], time_tick}
			           - {regs.start_time[srp_pkg::TIME_W-1], regs.start_time};
			region_s2 <= region_c;
			dlow_s2   <= d_s1[srp_pkg::DUR_W-1:0];
		end
	end

endmodule

// ===== src/srp_divider.sv =====
// srp_divider: pipelined restoring divider, one quotient bit per stage
// depends on srp_pkg; needs the quotient to fit in DIV_QB bits
module srp_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [srp_pkg::DIV_NB-1:0]  in_num,
	input  logic [srp_pkg::DIV_DB-1:0]  in_den,
	input  srp_pkg::side_t              in_side,
	output logic                        out_valid,
	output logic [srp_pkg::DIV_QB-1:0]  out_quo,
	output srp_pkg::side_t              out_side
);

	localparam int QB = srp_pkg::DIV_QB;
	localparam int DB = srp_pkg::DIV_DB;

	logic           valid_s [QB];
	logic [DB-1:0]  rem_s   [QB];
	logic [QB-1:0]  low_s   [QB];
	logic [DB-1:0]  den_s   [QB];
	logic [QB-1:0]  quo_s   [QB];
	srp_pkg::side_t side_s  [QB];

	logic           cur_valid [QB];
	logic [DB-1:0]  cur_rem   [QB];
	logic [QB-1:0]  cur_low   [QB];
	logic [DB-1:0]  cur_den   [QB];
	logic [QB-1:0]  cur_quo   [QB];
	srp_pkg::side_t cur_side  [QB];

	logic [DB:0]    trial [QB];
	logic [DB:0]    diff  [QB];
	logic           take  [QB];
	logic [DB-1:0]  nxt_rem [QB];
	logic [QB-1:0]  nxt_quo [QB];

	always_comb begin
		cur_valid[0] = in_valid;
		cur_rem[0]   = in_num[srp_pkg::DIV_NB-1:QB];
		cur_low[0]   = in_num[QB-1:0];
		cur_den[0]   = in_den;
		cur_quo[0]   = '0;
		cur_side[0]  = in_side;
		for (int k = 1; k < QB; k++) begin
			cur_valid[k] = valid_s[k-1];
			cur_rem[k]   = rem_s[k-1];
			cur_low[k]   = low_s[k-1];
			cur_den[k]   = den_s[k-1];
			cur_quo[k]   = quo_s[k-1];
			cur_side[k]  = side_s[k-1];
		end
		for (int k = 0; k < QB; k++) begin
			trial[k]   = {cur_rem[k], cur_low[k][QB-1-k]};
			diff[k]    = trial[k] - {1'b0, cur_den[k]};
			take[k]    = trial[k] >= {1'b0, cur_den[k]};
			nxt_rem[k] = take[k] ? diff[k][DB-1:0] : trial[k][DB-1:0];
			nxt_quo[k] = {cur_quo[k][QB-2:0], take[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QB; k++)
				valid_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < QB; k++)
				valid_s[k] <= cur_valid[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QB; k++) begin
				rem_s[k]  <= nxt_rem[k];
				low_s[k]  <= cur_low[k];
				den_s[k]  <= cur_den[k];
				quo_s[k]  <= nxt_quo[k];
				side_s[k] <= cur_side[k];
			end
		end
	end

	assign out_valid = valid_s[QB-1];
	assign out_quo   = quo_s[QB-1];
	assign out_side  = side_s[QB-1];

endmodule

// ===== src/srp_level.sv =====
// srp_level: ramp fraction, scaling by height, rounding, offset and saturation
// depends on srp_pkg; the last stage is the output register
module srp_level (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [srp_pkg::DIV_QB-1:0]  quo,
	input  srp_pkg::side_t              side,
	input  srp_pkg::cfg_t               regs,
	output logic                        valid_s8,
	output logic [srp_pkg::VAL_W-1:0]   level_s8,
	output srp_pkg::region_t            region_s8,
	output logic                        sat_s8
);

	logic                               valid_s5;
	logic                               valid_s6;
	logic                               valid_s7;
	logic signed [srp_pkg::F_W-1:0]     f_s5;
	logic signed [srp_pkg::PROD_W-1:0]  prod_s6;
	logic signed [srp_pkg::RND_W-1:0]   rnd_s7;
	srp_pkg::region_t                   region_s5;
	srp_pkg::region_t                   region_s6;
	srp_pkg::region_t                   region_s7;

	logic [srp_pkg::F_W-1:0]            q_c;
	logic [srp_pkg::F_W-1:0]            f_c;
	logic signed [srp_pkg::VAL_W-1:0]   h_c;
	logic signed [srp_pkg::PROD_W-1:0]  prod_c;
	logic [srp_pkg::PROD_W-1:0]         rsum_c;
	logic signed [srp_pkg::SUM_W-1:0]   tot_c;
	logic                               ovf_c;
	logic [srp_pkg::VAL_W-1:0]          lvl_c;

	always_comb begin
		q_c = {1'b0, quo};
		case (side.region)
			srp_pkg::REG_BEFORE: f_c = '0;
			srp_pkg::REG_LOWER:  f_c = q_c;
			srp_pkg::REG_LINEAR: f_c = side.neg ? (srp_pkg::F_HALF - q_c)
			                                    : (srp_pkg::F_HALF + q_c);
			srp_pkg::REG_UPPER:  f_c = srp_pkg::F_ONE - q_c;
			srp_pkg::REG_AFTER:  f_c = srp_pkg::F_ONE;
			default:             f_c = '0;
		endcase
	end

	assign h_c    = $signed(regs.ramp_height);
	assign prod_c = h_c * f_s5;
	// round half up, then floor by the arithmetic shift
	assign rsum_c = prod_s6 + srp_pkg::RND_HALF;

	always_comb begin
		tot_c = {{(srp_pkg::SUM_W-srp_pkg::VAL_W){regs.base_offset[srp_pkg::VAL_W-1]}},
		         regs.base_offset}
		      + {rnd_s7[srp_pkg::RND_W-1], rnd_s7};
		ovf_c = (tot_c[srp_pkg::SUM_W-1:srp_pkg::VAL_W-1] != '0)
		     && (tot_c[srp_pkg::SUM_W-1:srp_pkg::VAL_W-1] != '1);
		if (!ovf_c)
			lvl_c = tot_c[srp_pkg::VAL_W-1:0];
		else if (tot_c[srp_pkg::SUM_W-1])
			lvl_c = srp_pkg::VAL_MIN;
		else
			lvl_c = srp_pkg::VAL_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s5 <= in_valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s5      <= f_c;
			region_s5 <= side.region;
			prod_s6   <= prod_c;
			region_s6 <= region_s5;
			rnd_s7    <= rsum_c[srp_pkg::PROD_W-1:30];
			region_s7 <= region_s6;
			level_s8  <= lvl_c;
			region_s8 <= region_s7;
			sat_s8    <= ovf_c;
		end
	end

endmodule

// ===== src/smoothed_ramp_profile.sv =====
// smoothed_ramp_profile: top level of the ramp setpoint pipeline
// depends on srp_pkg, srp_cfg_regs, srp_region, srp_divider, srp_level
//
// Usage:
//   cfg_valid/cfg_index/cfg_data write one register per cycle (cfg_ready is
//   always high): 0 start_time, 1 ramp_duration, 2 smoothness, 3 base_offset,
//   4 ramp_height; other indexes are ignored. Write only while no item is in
//   flight.
//   s_tvalid/s_tready/s_tdata carry one time sample per item. m_tvalid,
//   m_tready, m_tdata and m_tuser carry one setpoint item per input item.
//   The pipeline is 70 register stages deep. Throughput is one item per
//   cycle while the output does not stall, as the two 31 stage dividers
//   (ramp position, then blend fraction) are fully pipelined.
//   The whole pipeline advances together; while the output item waits with
//   m_tready low, every stage holds and s_tready is low, so nothing is lost
//   or repeated. An empty output register lets the pipeline move on.
//   Reset clears all valid bits and loads the register reset values
//   (start 0, duration 1, smoothness 0, offset 0, height 1.0).
module smoothed_ramp_profile (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [srp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srp_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,   // [31:0] time_tick
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // [31:0] level
	output logic [3:0]                     m_tuser    // [2:0] region, [3] saturated
);

	srp_pkg::cfg_t                 regs;
	logic                          en;

	logic                          reg_valid;
	srp_pkg::region_t              reg_region;
	logic [srp_pkg::DUR_W-1:0]     reg_dlow;

	logic [srp_pkg::DIV_NB-1:0]    div1_num;
	srp_pkg::side_t                div1_side_in;
	logic                          div1_valid;
	logic [srp_pkg::DIV_QB-1:0]    div1_quo;
	srp_pkg::side_t                div1_side;

	logic                          valid_s3;
	logic                          valid_s4;
	logic [srp_pkg::DIV_QB-1:0]    w_s3;
	logic [srp_pkg::DIV_QB-1:0]    mag_s3;
	logic                          neg_s3;
	srp_pkg::region_t              region_s3;
	logic [srp_pkg::DIV_NB-1:0]    num_s4;
	logic [srp_pkg::DIV_DB-1:0]    den_s4;
	srp_pkg::side_t                side_s4;

	logic [srp_pkg::DIV_QB-1:0]    w_c;
	logic [srp_pkg::DIV_QB:0]      diff_c;
	logic [srp_pkg::DIV_QB:0]      magf_c;
	logic [srp_pkg::DIV_NB-1:0]    sq_c;
	logic [srp_pkg::DIV_NB-1:0]    num_c;
	logic [srp_pkg::DIV_DB-1:0]    den_c;
	srp_pkg::side_t                side_c;

	logic                          div2_valid;
	logic [srp_pkg::DIV_QB-1:0]    div2_quo;
	srp_pkg::side_t                div2_side;

	logic [srp_pkg::VAL_W-1:0]     level;
	srp_pkg::region_t              region;
	logic                          sat;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	srp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	srp_region u_region (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.time_tick (s_tdata),
		.regs      (regs),
		.valid_s2  (reg_valid),
		.region_s2 (reg_region),
		.dlow_s2   (reg_dlow)
	);

	// ramp position u = d * 2^30 / R
	assign div1_num = {1'b0, reg_dlow, 30'b0};

	always_comb begin
		div1_side_in.region = reg_region;
		div1_side_in.neg    = 1'b0;
	end

	srp_divider u_div_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (reg_valid),
		.in_num    (div1_num),
		.in_den    (regs.r_eff),
		.in_side   (div1_side_in),
		.out_valid (div1_valid),
		.out_quo   (div1_quo),
		.out_side  (div1_side)
	);

	always_comb begin
		w_c    = (div1_side.region == srp_pkg::REG_UPPER) ? (srp_pkg::U_ONE - div1_quo)
		                                                   : div1_quo;
		diff_c = {1'b0, div1_quo} - {1'b0, srp_pkg::U_HALF};
		magf_c = diff_c[srp_pkg::DIV_QB] ? (~diff_c + 1'b1) : diff_c;
	end

	always_comb begin
		sq_c = w_s3 * w_s3;
		if (region_s3 == srp_pkg::REG_LINEAR) begin
			num_c = {15'b0, mag_s3, 16'b0};
			den_c = {14'b0, regs.s_comp};
		end else begin
			num_c = {sq_c[srp_pkg::DIV_NB-2:0], 1'b0};
			den_c = regs.dd;
		end
		side_c.region = region_s3;
		side_c.neg    = neg_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= div1_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s3      <= w_c;
			mag_s3    <= magf_c[srp_pkg::DIV_QB-1:0];
			neg_s3    <= diff_c[srp_pkg::DIV_QB];
			region_s3 <= div1_side.region;
			num_s4    <= num_c;
			den_s4    <= den_c;
			side_s4   <= side_c;
		end
	end

	srp_divider u_div_frac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.in_num    (num_s4),
		.in_den    (den_s4),
		.in_side   (side_s4),
		.out_valid (div2_valid),
		.out_quo   (div2_quo),
		.out_side  (div2_side)
	);

	srp_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div2_valid),
		.quo       (div2_quo),
		.side      (div2_side),
		.regs      (regs),
		.valid_s8  (m_tvalid),
		.level_s8  (level),
		.region_s8 (region),
		.sat_s8    (sat)
	);

	assign m_tdata = level;
	assign m_tuser = {sat, region};

	// before the start the level is the offset and cannot clip
	a_before_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] == srp_pkg::REG_BEFORE) |-> !m_tuser[3])
		else $error("saturation flagged before ramp start");

	// a stalled output freezes both dividers
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(div1_valid) && $stable(div2_valid) && $stable(div2_quo))
		else $error("divider pipeline moved during stall");

endmodule

// ===== tb/sv/tb_smoothed_ramp_profile.sv =====
// tb_smoothed_ramp_profile: self-checking testbench for the smoothed ramp profile block
// directed table then randomized profiles; setpoints checked by local predictor or pinned rows
// depends on srp_pkg and smoothed_ramp_profile
`timescale 1ns / 100ps

module tb_smoothed_ramp_profile;

	localparam int PLAN_LEN       = 46;
	localparam int N_PHASES       = 11;
	localparam int PRESSURE_PHASE = 2;
	localparam int PHASE_ITEMS    = 50;
	localparam int PRESSURE_ITEMS = 120;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 80;

	localparam longint Q30_ONE  = 64'sd1073741824;
	localparam longint Q30_HALF = 64'sd536870912;
	localparam longint LVL_HI   = 64'sd2147483647;
	localparam longint LVL_LO   = -64'sd2147483648;

	localparam logic ROW_CFG  = 1'b1;
	localparam logic ROW_TICK = 1'b0;

	localparam logic [srp_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [srp_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic [srp_pkg::CFG_IDX_W-1:0] IDX_NONE     = '0;

	typedef struct packed {
		logic [srp_pkg::VAL_W-1:0] level;
		srp_pkg::region_t          region;
		logic                      saturated;
	} setpoint_t;

	typedef struct packed {
		logic                          is_cfg;
		logic                          pinned;
		logic [srp_pkg::CFG_IDX_W-1:0] idx;
		logic [31:0]                   val;
		setpoint_t                     res;
	} plan_row_t;

	localparam setpoint_t NO_SETPOINT = '0;

	// tick rows carry the time in val; pinned rows carry the setpoint worked out by hand
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ROW_TICK, 1'b1, IDX_NONE, 32'h0000_0000, '{32'h0000_0000, srp_pkg::REG_BEFORE, 1'b0}},
		'{ROW_TICK, 1'b1, IDX_NONE, 32'h0000_0001, '{32'h0001_0000, srp_pkg::REG_LINEAR, 1'b0}},
		'{ROW_TICK, 1'b1, IDX_NONE, 32'h0000_0002, '{32'h0001_0000, srp_pkg::REG_AFTER, 1'b0}},
		'{ROW_TICK, 1'b1, IDX_NONE, 32'h8000_0000, '{32'h0000_0000, srp_pkg::REG_BEFORE, 1'b0}},
		'{ROW_TICK, 1'b1, IDX_NONE, 32'h7FFF_FFFF, '{32'h0001_0000, srp_pkg::REG_AFTER, 1'b0}},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_START_TIME, 32'h8000_0000, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_RAMP_DURATION, 32'h0000_0000, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_SMOOTHNESS, 32'h0000_FFFF, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_BASE_OFFSET, 32'h7FFF_FFFF, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_RAMP_HEIGHT, 32'h7FFF_FFFF, NO_SETPOINT},
		'{ROW_CFG, 1'b0, CFG_SPARE_LO, 32'h1234_5678, NO_SETPOINT},
		'{ROW_CFG, 1'b0, CFG_SPARE_HI, 32'hFFFF_FFFF, NO_SETPOINT},
		'{ROW_TICK, 1'b1, IDX_NONE, 32'h7FFF_FFFF,
			'{srp_pkg::VAL_MAX, srp_pkg::REG_AFTER, 1'b1}},
		'{ROW_TICK, 1'b1, IDX_NONE, 32'h8000_0000, '{32'h7FFF_FFFF, srp_pkg::REG_BEFORE, 1'b0}},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'h8000_0001, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_START_TIME, 32'h0000_0000, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_RAMP_DURATION, 32'h7FFF_FFFF, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_SMOOTHNESS, 32'h0000_8000, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_BASE_OFFSET, 32'h8000_0000, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_RAMP_HEIGHT, 32'h8000_0000, NO_SETPOINT},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'h7FFF_FFFF, NO_SETPOINT},
		'{ROW_TICK, 1'b1, IDX_NONE, 32'h8000_0000,
			'{srp_pkg::VAL_MIN, srp_pkg::REG_BEFORE, 1'b0}},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'h0000_0001, NO_SETPOINT},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'h3FFF_FFFF, NO_SETPOINT},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'h4000_0000, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_START_TIME, 32'd100, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_RAMP_DURATION, 32'd1000, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_SMOOTHNESS, 32'd0, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_BASE_OFFSET, 32'd0, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_RAMP_HEIGHT, 32'h0010_0000, NO_SETPOINT},
		'{ROW_TICK, 1'b1, IDX_NONE, 32'd100, '{32'h0000_0000, srp_pkg::REG_BEFORE, 1'b0}},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'd600, NO_SETPOINT},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'd1100, NO_SETPOINT},
		'{ROW_TICK, 1'b1, IDX_NONE, 32'd1101, '{32'h0010_0000, srp_pkg::REG_AFTER, 1'b0}},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_START_TIME, 32'hFFFF_FFCE, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_RAMP_DURATION, 32'd200, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_SMOOTHNESS, 32'h0000_4000, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_BASE_OFFSET, 32'h0000_3039, NO_SETPOINT},
		'{ROW_CFG, 1'b0, srp_pkg::CFG_RAMP_HEIGHT, 32'hFF00_0000, NO_SETPOINT},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'hFFFF_FFCF, NO_SETPOINT},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'd0, NO_SETPOINT},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'd1, NO_SETPOINT},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'd100, NO_SETPOINT},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'd101, NO_SETPOINT},
		'{ROW_TICK, 1'b0, IDX_NONE, 32'd150, NO_SETPOINT},
		'{ROW_TICK, 1'b1, IDX_NONE, 32'd151, '{32'hFF00_3039, srp_pkg::REG_AFTER, 1'b0}}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [srp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [srp_pkg::CFG_DAT_W-1:0] cfg_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [31:0]                   s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [31:0]                   m_tdata;
	logic [3:0]                    m_tuser;

	logic [31:0] cfg_start  = '0;
	logic [30:0] cfg_dur    = 31'd1;
	logic [15:0] cfg_smooth = '0;
	logic [31:0] cfg_offset = '0;
	logic [31:0] cfg_height = 32'h0001_0000;

	setpoint_t setpoint_q [$];
	logic      pin_valid = 1'b0;
	setpoint_t pin_setpoint = '0;
	bit        gaps_on = 1'b1;
	bit        stalls_on = 1'b1;
	bit        hold_req = 1'b0;
	int        mismatches = 0;
	int        idle_cycles = 0;

	smoothed_ramp_profile dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic setpoint_t calc_setpoint(logic [31:0] tick);
		longint d, r, s, u, den, f, v, off, h, acc;
		setpoint_t sp;
		d = longint'($signed(tick)) - longint'($signed(cfg_start));
		r = cfg_dur;
		if (r == 0)
			r = 1;
		s = cfg_smooth;
		if (s > 32768)
			s = 32768;
		off = longint'($signed(cfg_offset));
		h = longint'($signed(cfg_height));
		f = 0;
		if (d <= 0)
			sp.region = srp_pkg::REG_BEFORE;
		else if (d > r)
			sp.region = srp_pkg::REG_AFTER;
		else if (65536 * d <= s * r)
			sp.region = srp_pkg::REG_LOWER;
		else if (65536 * d <= 65536 * r - s * r)
			sp.region = srp_pkg::REG_LINEAR;
		else
			sp.region = srp_pkg::REG_UPPER;
		u = (d * Q30_ONE) / r;
		den = s * (65536 - s);
		case (sp.region)
			srp_pkg::REG_LOWER: f = (den > 0) ? (2 * u * u) / den : 0;
			srp_pkg::REG_LINEAR: f = Q30_HALF + ((u - Q30_HALF) * 65536) / (65536 - s);
			srp_pkg::REG_UPPER: begin
				v = Q30_ONE - u;
				f = Q30_ONE - ((den > 0) ? (2 * v * v) / den : 0);
			end
			default: ;
		endcase
		if (sp.region == srp_pkg::REG_BEFORE)
			acc = off;
		else if (sp.region == srp_pkg::REG_AFTER)
			acc = off + h;
		else
			acc = off + ((h * f + Q30_HALF) >>> 30);
		sp.saturated = 1'b0;
		if (acc > LVL_HI) begin
			sp.level = srp_pkg::VAL_MAX;
			sp.saturated = 1'b1;
		end else if (acc < LVL_LO) begin
			sp.level = srp_pkg::VAL_MIN;
			sp.saturated = 1'b1;
		end else begin
			sp.level = acc[31:0];
		end
		return sp;
	endfunction

	// times clustered around the ramp and its blend edges, with some anywhere
	function automatic logic [31:0] pick_tick();
		longint r, s, b, ofs;
		r = cfg_dur;
		if (r == 0)
			r = 1;
		s = cfg_smooth;
		if (s > 32768)
			s = 32768;
		b = (s * r) >>> 16;
		case ($urandom_range(0, 9))
			0: ofs = $urandom;
			1: begin
				case ($urandom_range(0, 7))
					0: ofs = 0;
					1: ofs = 1;
					2: ofs = r;
					3: ofs = r + 1;
					4: ofs = b;
					5: ofs = b + 1;
					6: ofs = r - b;
					default: ofs = r - b + 1;
				endcase
			end
			default: ofs = longint'($urandom_range(0, 32'(r + r / 4 + 1))) - r / 8 - 1;
		endcase
		return cfg_start + ofs[31:0];
	endfunction

	function automatic logic [31:0] pick_q16();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? srp_pkg::VAL_MAX : srp_pkg::VAL_MIN;
			default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
		endcase
	endfunction

	task automatic write_reg(logic [srp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_tick(logic [31:0] tick, logic pinned, setpoint_t res);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = tick;
		pin_valid = pinned;
		pin_setpoint = res;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_setpoints();
		@(negedge clk);
		s_tvalid = 1'b0;
		pin_valid = 1'b0;
		while (setpoint_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic pick_profile();
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			default: v = $urandom_range(0, 2000000) - 1000000;
		endcase
		write_reg(srp_pkg::CFG_START_TIME, v);
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = 0;
			2: v = $urandom_range(1, 8);
			default: v = $urandom_range(9, 200000);
		endcase
		write_reg(srp_pkg::CFG_RAMP_DURATION, v);
		case ($urandom_range(0, 5))
			0: v = 0;
			1: v = 32'h0000_8000;
			2: v = $urandom_range(32769, 65535);
			3: v = $urandom;
			default: v = $urandom_range(1, 32767);
		endcase
		write_reg(srp_pkg::CFG_SMOOTHNESS, v);
		write_reg(srp_pkg::CFG_BASE_OFFSET, pick_q16());
		write_reg(srp_pkg::CFG_RAMP_HEIGHT, pick_q16());
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
	endtask

	always @(posedge clk) begin : scoreboard
		setpoint_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_index)
					srp_pkg::CFG_START_TIME: cfg_start = cfg_data;
					srp_pkg::CFG_RAMP_DURATION: cfg_dur = cfg_data[30:0];
					srp_pkg::CFG_SMOOTHNESS: cfg_smooth = cfg_data[15:0];
					srp_pkg::CFG_BASE_OFFSET: cfg_offset = cfg_data;
					srp_pkg::CFG_RAMP_HEIGHT: cfg_height = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				setpoint_q.push_back(pin_valid ? pin_setpoint : calc_setpoint(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				if (setpoint_q.size() == 0) begin
					$error("setpoint item with none expected: level %h tuser %h", m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = setpoint_q.pop_front();
					if (m_tdata !== want.level) begin
						$error("level: expected %h, got %h", want.level, m_tdata);
						mismatches++;
					end
					if (m_tuser[2:0] !== want.region) begin
						$error("region: expected %0d, got %0d", want.region, m_tuser[2:0]);
						mismatches++;
					end
					if (m_tuser[3] !== want.saturated) begin
						$error("saturated: expected %0d, got %0d", want.saturated, m_tuser[3]);
						mismatches++;
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", idle_cycles);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// output side: random stall bursts, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				m_tready = 1'b1;
				hold_req = 1'b0;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				m_tready = 1'b1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	initial begin
		bit streaming;
		int n;
		streaming = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].is_cfg) begin
				if (streaming) begin
					drain_setpoints();
					streaming = 1'b0;
				end
				write_reg(PLAN[i].idx, PLAN[i].val);
			end else begin
				send_tick(PLAN[i].val, PLAN[i].pinned, PLAN[i].res);
				streaming = 1'b1;
			end
		end
		drain_setpoints();

		for (int p = 0; p < N_PHASES; p++) begin
			gaps_on = (p != N_PHASES - 1) && (p != PRESSURE_PHASE);
			stalls_on = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
			pick_profile();
			if (p == PRESSURE_PHASE)
				hold_req = 1'b1;
			n = (p == PRESSURE_PHASE) ? PRESSURE_ITEMS : PHASE_ITEMS;
			repeat (n) send_tick(pick_tick(), 1'b0, NO_SETPOINT);
			drain_setpoints();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== smoothed_ramp_profile.f =====
src/srp_pkg.sv
src/srp_cfg_regs.sv
src/srp_region.sv
src/srp_divider.sv
src/srp_level.sv
src/smoothed_ramp_profile.sv
tb/sv/tb_smoothed_ramp_profile.sv
